// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL; vid_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active (active-low reset).
`define VID_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define VID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/vid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vid_pkg
// Shared types and constants of the vertex index deduplication block.
// ----------------------------------------------------------------------------
package vid_pkg;

    localparam int SLOT_W   = 20;
    localparam int VIDX_W   = 16;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONPOS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_VTX_LIMIT = 2'd3;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic CFG_POSITION_COUNT = 1'b0;
    localparam logic CFG_NORMAL_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_REJECT,
        KIND_LOOKUP
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    pslot;
        logic [SLOT_W-1:0]    nslot;
        logic                 defn;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 defn;
        logic [SLOT_W-1:0]    nslot;
        logic [SLOT_W-1:0]    pslot;
        logic                 created;
        logic [VIDX_W-1:0]    vidx;
    } result_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_CMP,
        B_FIN
    } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vid_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vid_front
// Classifies a face corner: clear, rejected, or lookup with its slots and key.
// ----------------------------------------------------------------------------
module vid_front #(
    parameter int INDEX_BITS = 21
) (
    input  wire logic                          op,
    input  wire logic [INDEX_BITS-1:0]         pos_index,
    input  wire logic [INDEX_BITS-1:0]         norm_index,
    input  wire logic [vid_pkg::SLOT_W-1:0]    position_count,
    input  wire logic [vid_pkg::SLOT_W-1:0]    normal_count,
    output vid_pkg::item_t                     item,
    output logic [vid_pkg::SLOT_W+INDEX_BITS-1:0] key
);
    localparam int CW = (INDEX_BITS > vid_pkg::SLOT_W) ? INDEX_BITS : vid_pkg::SLOT_W;

    logic [INDEX_BITS-1:0] pos_m1;
    logic [INDEX_BITS-1:0] norm_m1;
    logic [CW-1:0]         pos_m1_ext;
    logic [CW-1:0]         norm_m1_ext;
    logic                  pos_pos;
    logic                  norm_pos;

    assign pos_m1      = pos_index - INDEX_BITS'(1);
    assign norm_m1     = norm_index - INDEX_BITS'(1);
    assign pos_m1_ext  = CW'(pos_m1);
    assign norm_m1_ext = CW'(norm_m1);
    assign pos_pos     = !pos_index[INDEX_BITS-1] && (pos_index != '0);
    assign norm_pos    = !norm_index[INDEX_BITS-1] && (norm_index != '0);
    assign key         = {norm_index, pos_m1_ext[vid_pkg::SLOT_W-1:0] +
                          vid_pkg::SLOT_W'(1)};

    always_comb begin
        item        = '0;
        item.kind   = vid_pkg::KIND_LOOKUP;
        item.status = vid_pkg::ST_OK;
        item.defn   = 1'b1;
        priority if (op == vid_pkg::OP_CLEAR) begin
            item.kind = vid_pkg::KIND_CLEAR;
        end else if (!pos_pos) begin
            item.kind   = vid_pkg::KIND_REJECT;
            item.status = vid_pkg::ST_NONPOS;
            item.defn   = 1'b0;
        end else if (pos_m1_ext >= CW'(position_count)) begin
            item.kind   = vid_pkg::KIND_REJECT;
            item.status = vid_pkg::ST_POS_RANGE;
            item.defn   = 1'b0;
        end else begin
            item.pslot = pos_m1_ext[vid_pkg::SLOT_W-1:0];
            if (norm_pos && (norm_m1_ext < CW'(normal_count))) begin
                item.nslot = norm_m1_ext[vid_pkg::SLOT_W-1:0];
                item.defn  = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vid_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vid_queue
// Two-entry queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module vid_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      pop_data
);
    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vid_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// vid_back
// Key table engine: scans stored keys, allocates new vertices, holds results.
// ----------------------------------------------------------------------------
module vid_back #(
    parameter int MAX_VERTICES = 65535,
    parameter int KEY_W        = 41
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire vid_pkg::item_t    q_item,
    input  wire logic [KEY_W-1:0]  q_key,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output vid_pkg::result_t       m_result
);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [KEY_W-1:0] key_mem [MAX_VERTICES];

    vid_pkg::back_state_t state_reg, state_next;
    logic [VW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    vid_pkg::item_t       cur_reg, cur_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 found_reg, found_next;
    logic [KEY_W-1:0]     rd_key_reg;
    logic                 out_valid_reg, out_valid_next;
    vid_pkg::result_t     out_reg, out_next;
    logic                 slot_free;
    logic                 mem_we;

    assign slot_free = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        unique case (state_reg)
            vid_pkg::B_IDLE: begin
                if (q_valid && slot_free) begin
                    q_pop = 1'b1;
                    unique case (q_item.kind)
                        vid_pkg::KIND_CLEAR: begin
                            count_next     = '0;
                            out_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        vid_pkg::KIND_REJECT: begin
                            out_next        = '0;
                            out_next.status = q_item.status;
                            out_valid_next  = 1'b1;
                        end
                        default: begin
                            cur_next   = q_item;
                            key_next   = q_key;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = (count_reg == '0) ? vid_pkg::B_FIN
                                                           : vid_pkg::B_READ;
                        end
                    endcase
                end
            end
            vid_pkg::B_READ: begin
                state_next = vid_pkg::B_CMP;
            end
            vid_pkg::B_CMP: begin
                if (rd_key_reg == key_reg) begin
                    found_next = 1'b1;
                    state_next = vid_pkg::B_FIN;
                end else if (CW'(idx_reg) + CW'(1) == count_reg) begin
                    state_next = vid_pkg::B_FIN;
                end else begin
                    idx_next   = idx_reg + VW'(1);
                    state_next = vid_pkg::B_READ;
                end
            end
            vid_pkg::B_FIN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    state_next     = vid_pkg::B_IDLE;
                    if (found_reg) begin
                        out_next.vidx  = vid_pkg::VIDX_W'(idx_reg);
                        out_next.pslot = cur_reg.pslot;
                        out_next.nslot = cur_reg.nslot;
                        out_next.defn  = cur_reg.defn;
                    end else if (count_reg >= CW'(MAX_VERTICES)) begin
                        out_next.status = vid_pkg::ST_VTX_LIMIT;
                    end else begin
                        mem_we           = 1'b1;
                        count_next       = count_reg + CW'(1);
                        out_next.vidx    = vid_pkg::VIDX_W'(count_reg);
                        out_next.created = 1'b1;
                        out_next.pslot   = cur_reg.pslot;
                        out_next.nslot   = cur_reg.nslot;
                        out_next.defn    = cur_reg.defn;
                    end
                end
            end
            default: begin
                state_next = vid_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vid_pkg::B_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[count_reg[VW-1:0]] <= key_reg;
        end
        if (state_reg == vid_pkg::B_READ) begin
            rd_key_reg <= key_mem[idx_reg];
        end
    end

    `VID_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(MAX_VERTICES), "vertex count over limit")
    `VID_ASSERT(a_scan_in_range, aclk, aresetn, (state_reg == vid_pkg::B_CMP) |-> (CW'(idx_reg) < count_reg), "scan beyond stored vertices")
    `VID_ASSERT(a_created_ok, aclk, aresetn, (out_valid_reg && out_reg.created) |-> (out_reg.status == vid_pkg::ST_OK), "created with error status")
    `VID_ASSERT(a_write_has_room, aclk, aresetn, mem_we |=> (count_reg == $past(count_reg) + CW'(1)), "allocation did not advance count")

endmodule
`default_nettype wire

// ===== hw/rtl/vertex_index_dedup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A lookup reads and compares the stored vertices one at a time (B_READ, then B_CMP)
// until the match, or all of them for a new key; no new corner is taken meanwhile.
// Clear and rejected corners sustain one per cycle through the two-entry queue while
// m_tready is high and no lookup is in progress.
// Reset (aresetn low, synchronous) empties the table and zeroes both counts.
// ----------------------------------------------------------------------------
// vertex_index_dedup
// Merges face corners with equal (position, normal) keys into one vertex index.
// ----------------------------------------------------------------------------
module vertex_index_dedup #(
    parameter int MAX_VERTICES = 65535,
    parameter int INDEX_BITS   = 21
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [vid_pkg::SLOT_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pos_index, norm_index, zero pad
    input  wire logic [((2*INDEX_BITS+7)/8)*8-1:0] s_tdata,
    // op
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // vertex_index, created, position_slot, normal_slot, default_normal, status, zero pad
    output logic [63:0]                          m_tdata
);
    localparam int KEY_W = vid_pkg::SLOT_W + INDEX_BITS;
    localparam int Q_W   = KEY_W + $bits(vid_pkg::item_t);

    logic [vid_pkg::SLOT_W-1:0] position_count_reg;
    logic [vid_pkg::SLOT_W-1:0] normal_count_reg;
    vid_pkg::item_t             f_item;
    logic [KEY_W-1:0]           f_key;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;
    logic [Q_W-1:0]             q_data;
    vid_pkg::result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_count_reg <= '0;
            normal_count_reg   <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == vid_pkg::CFG_POSITION_COUNT) begin
                position_count_reg <= cfg_data;
            end else begin
                normal_count_reg <= cfg_data;
            end
        end
    end

    vid_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .op             (s_tuser),
        .pos_index      (s_tdata[INDEX_BITS-1:0]),
        .norm_index     (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
        .position_count (position_count_reg),
        .normal_count   (normal_count_reg),
        .item           (f_item),
        .key            (f_key)
    );

    assign s_tready = !q_full;

    vid_queue #(.W(Q_W)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && !q_full),
        .push_data ({f_key, f_item}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    vid_back #(.MAX_VERTICES(MAX_VERTICES), .KEY_W(KEY_W)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (vid_pkg::item_t'(q_data[$bits(vid_pkg::item_t)-1:0])),
        .q_key    (q_data[Q_W-1:$bits(vid_pkg::item_t)]),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (res)
    );

    assign m_tdata = {4'b0000, res};

endmodule
`default_nettype wire

// ===== test/vertex_index_dedup_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_index_dedup_tb
// Drives face corners and clears with random handshake gaps, predicts the
// vertex index, slots and status of each corner and compares every result.
// ----------------------------------------------------------------------------
module vertex_index_dedup_tb;

    localparam int IB = 21;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic          op;
        logic [IB-1:0] pos;
        logic [IB-1:0] norm;
    } corner_t;

    typedef struct packed {
        logic [15:0] vidx;
        logic        created;
        logic [19:0] pslot;
        logic [19:0] nslot;
        logic        defn;
        logic [1:0]  status;
    } vertex_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [vid_pkg::SLOT_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;

    always #5 aclk = ~aclk;

    vertex_index_dedup dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),     // pos_index, norm_index, zero pad
        .s_tuser(s_tuser),     // op
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)      // vertex_index, created, position_slot, normal_slot,
                               // default_normal, status, zero pad
    );

    corner_t     corner_q[$];
    vertex_res_t expected_q[$];
    logic [40:0] key_table[$];
    logic [19:0] pos_count = '0;
    logic [19:0] norm_count = '0;
    int errors = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int hold_rx = 0;
    bit tx_pause = 0;

    function automatic vertex_res_t dedup_predict(corner_t c);
        vertex_res_t r;
        logic signed [IB-1:0] p, n;
        logic [40:0] key;
        int hit;
        r = '0;
        p = c.pos;
        n = c.norm;
        if (c.op == vid_pkg::OP_CLEAR) begin
            key_table.delete();
            return r;
        end
        if (p <= 0) begin
            r.status = vid_pkg::ST_NONPOS;
            return r;
        end
        if (32'(p - 1) >= 32'(pos_count)) begin
            r.status = vid_pkg::ST_POS_RANGE;
            return r;
        end
        key = {c.norm, 20'(p)};
        hit = -1;
        foreach (key_table[i])
            if (hit < 0 && key_table[i] == key) hit = i;
        if (hit < 0) begin
            if (key_table.size() >= 65535) begin
                r.status = vid_pkg::ST_VTX_LIMIT;
                return r;
            end
            hit = key_table.size();
            key_table.insert(key_table.size(), key);
            r.created = 1'b1;
        end
        r.vidx = 16'(hit);
        r.pslot = 20'(p - 1);
        if (n > 0 && 32'(n - 1) < 32'(norm_count)) begin
            r.nslot = 20'(n - 1);
            r.defn = 1'b0;
        end else begin
            r.defn = 1'b1;
        end
        r.status = vid_pkg::ST_OK;
        return r;
    endfunction

    // driver
    int tx_wait = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(), dedup_predict(corner_q.pop_front()));
                tx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if ((!s_tvalid || s_tready) ) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (corner_q.size() > 0 && !tx_pause) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= corner_q[0].op;
                    s_tdata <= {6'b0, corner_q[0].norm, corner_q[0].pos};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int rx_wait = 0;
    always @(posedge aclk) begin
        vertex_res_t got, exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[16], m_tdata[36:17], m_tdata[56:37],
                       m_tdata[57], m_tdata[59:58]};
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("unexpected result %h", m_tdata);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r || m_tdata[63:60] !== 4'b0) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp vidx=%0d cr=%0b ps=%0d ns=%0d dn=%0b st=%0d",
                                     exp_r.vidx, exp_r.created, exp_r.pslot, exp_r.nslot,
                                     exp_r.defn, exp_r.status,
                                     " got vidx=%0d cr=%0b ps=%0d ns=%0d dn=%0b st=%0d",
                                     got.vidx, got.created, got.pslot, got.nslot,
                                     got.defn, got.status);
                    end
                end
                rx_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (hold_rx > 0) begin
                hold_rx--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || hold_rx > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("vertex_index_dedup_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [19:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == vid_pkg::CFG_POSITION_COUNT) pos_count = val;
        else norm_count = val;
    endtask

    task automatic wait_drained();
        while (corner_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_corner(logic op, int p, int n);
        corner_t c;
        c.op = op;
        c.pos = IB'(p);
        c.norm = IB'(n);
        corner_q.insert(corner_q.size(), c);
    endtask

    // mostly valid corners drawn from a small pool so keys repeat
    task automatic add_random(int n_items, int pool);
        int r;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                add_corner(vid_pkg::OP_CLEAR, $urandom, $urandom);
            else if (r < 10)
                add_corner(vid_pkg::OP_LOOKUP, $urandom, $urandom);
            else if (r < 15)
                add_corner(vid_pkg::OP_LOOKUP, int'(pos_count) + $urandom_range(1, 3),
                           $urandom_range(0, 1) ? -1 : $urandom);
            else
                add_corner(vid_pkg::OP_LOOKUP, $urandom_range(1, pool),
                           $urandom_range(0, 3) == 0 ? -1 :
                           ($urandom_range(0, 7) == 0 ? $urandom :
                            $urandom_range(0, pool + 1)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: zero counts reject everything
        add_corner(vid_pkg::OP_LOOKUP, 1, 1);
        wait_drained();
        write_reg(vid_pkg::CFG_POSITION_COUNT, 20'hFFFFF);
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'hFFFFF);
        add_corner(vid_pkg::OP_LOOKUP, 0, 1);
        add_corner(vid_pkg::OP_LOOKUP, -1048576, 5);
        add_corner(vid_pkg::OP_LOOKUP, -1, -1);
        add_corner(vid_pkg::OP_LOOKUP, 1048575, 1048575);
        add_corner(vid_pkg::OP_LOOKUP, 1, -1);
        add_corner(vid_pkg::OP_LOOKUP, 1, -1);
        add_corner(vid_pkg::OP_LOOKUP, 1, 0);
        add_corner(vid_pkg::OP_LOOKUP, 1, -1048576);
        add_corner(vid_pkg::OP_LOOKUP, 1048575, 1048575);
        add_corner(vid_pkg::OP_LOOKUP, 2, 1);
        add_corner(vid_pkg::OP_CLEAR, 0, 0);
        add_corner(vid_pkg::OP_LOOKUP, 2, 1);
        add_corner(vid_pkg::OP_CLEAR, -1, -1);
        wait_drained();
        write_reg(vid_pkg::CFG_POSITION_COUNT, 20'd4);
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'd2);
        add_corner(vid_pkg::OP_LOOKUP, 4, 2);
        add_corner(vid_pkg::OP_LOOKUP, 5, 2);
        add_corner(vid_pkg::OP_LOOKUP, 4, 3);
        add_corner(vid_pkg::OP_LOOKUP, 4, 2);
        add_corner(vid_pkg::OP_LOOKUP, 3, 2);
        wait_drained();
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'd0);
        add_corner(vid_pkg::OP_LOOKUP, 4, 2);
        wait_drained();
        // random phases, extremes of the counts included
        write_reg(vid_pkg::CFG_POSITION_COUNT, 20'd40);
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'd30);
        add_random(150, 48);
        // long receiver hold while the sender keeps offering
        hold_rx = 300;
        wait_drained();
        write_reg(vid_pkg::CFG_POSITION_COUNT, 20'hFFFFF);
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'd1);
        add_random(200, 60);
        wait_drained();
        write_reg(vid_pkg::CFG_POSITION_COUNT, 20'd1);
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'hFFFFF);
        add_random(100, 3);
        wait_drained();
        write_reg(vid_pkg::CFG_POSITION_COUNT, 20'd20);
        write_reg(vid_pkg::CFG_NORMAL_COUNT, 20'd20);
        add_random(150, 24);
        // sender pause until all results are in
        tx_pause = 1;
        while (s_tvalid || expected_q.size() > 0) @(posedge aclk);
        tx_pause = 0;
        add_random(250, 24);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("vertex_index_dedup_tb OK");
        else
            $display("vertex_index_dedup_tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vid_pkg.sv
hw/rtl/vid_front.sv
hw/rtl/vid_queue.sv
hw/rtl/vid_back.sv
hw/rtl/vertex_index_dedup.sv
test/vertex_index_dedup_tb.sv
